### rtl/msse_pkg.sv
// Shared types and constants for the multiset subset enumerator.
// No dependencies; used by msse_ctrl, msse_dp and the top level.
`timescale 1ns / 1ps

package msse_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned NUM_W        = 16;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned MAX_ITEMS_DEF = 16;

  // Request kinds carried on the slave-side tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_TEST,
    ST_INS_CMP,
    ST_BT_RDV,
    ST_BT_LDV,
    ST_BT_CMP,
    ST_EM_RD,
    ST_EM_WR,
    ST_ONE_EMPTY,
    ST_ONE_DONE
  } state_e;

  // Source of the store read address
  typedef enum logic [2:0] {
    RD_INS,
    RD_TOP,
    RD_TOP_P1,
    RD_J_P1,
    RD_EMIT
  } rd_sel_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    OUT_ELEM,
    OUT_EMPTY,
    OUT_DONE
  } out_kind_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic      clear;
    logic      restart;
    logic      ld_val;
    logic      ins_step;
    logic      ins_put;
    rd_sel_e   rd_sel;
    logic      start_empty;
    logic      out_load;
    out_kind_e out_kind;
    logic      cnt_inc;
    logic      set_finished;
    logic      push;
    logic      bt_ldv;
    logic      bt_next;
    logic      bt_set;
    logic      pop;
    logic      k_inc;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic started;
    logic finished;
    logic can_push;
    logic depth_zero;
    logic depth_one;
    logic p_zero;
    logic ins_gt;
    logic top_end;
    logic j_end;
    logic scan_eq;
    logic k_last;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/multiset_subset_enumerator_top.sv
// Top level of the multiset subset enumerator: stream ports, controller
// and datapath. Depends on msse_pkg, msse_ctrl and msse_dp.
`timescale 1ns / 1ps

// Requests arrive on the slave stream with the command on tuser (0 clear,
// 1 load value, 2 next subset) and the signed value on tdata. Loaded values
// are kept sorted by insertion into a store memory with one read port: a
// load shifts up each held entry larger than the new one, then places it.
// A next request gives the empty set first, then each distinct
// sub-multiset in depth-first lexicographic order, one result per element
// with tlast on the final one, then a result flagged done, repeated until
// a clear or load restarts the enumeration. Each element result passes
// through the chosen index lookup with the registered store read, then the
// output register load, which waits while the output register is occupied;
// moving to the next subset reads and tests the top for each level given up
// and compares the following entries for the level that moves on, skipping
// equal entries while backtracking. A request is taken only while the
// controller is idle; a finished result waits in the output register
// without blocking the next request.
module multiset_subset_enumerator_top #(
  parameter int unsigned MAX_ITEMS = msse_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] element_value, [35:32] position_in_subset,
                                      // [51:36] subset_number, [55:52] zero
  output logic [1:0]  m_axis_tuser,   // [0] subset_empty, [1] done_res
  output logic        m_axis_tlast    // last_element
);

  msse_pkg::dp_cmd_t dp_cmd;
  msse_pkg::dp_sts_t dp_sts;

  logic signed [msse_pkg::DATA_W-1:0] element_value;
  logic [msse_pkg::IDX_W-1:0]         position;
  logic [msse_pkg::NUM_W-1:0]         subset_number;
  logic                               subset_empty;
  logic                               done_res;

  // Sequence each request
  msse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (s_axis_tuser),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Store, enumeration state and output register
  msse_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         ($signed(s_axis_tdata)),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .element_value_o (element_value),
    .position_o      (position),
    .subset_empty_o  (subset_empty),
    .last_element_o  (m_axis_tlast),
    .subset_number_o (subset_number),
    .done_o          (done_res)
  );

  // Pack the result fields
  assign m_axis_tdata = {4'b0000, subset_number, position, element_value};
  assign m_axis_tuser = {done_res, subset_empty};

endmodule

### rtl/msse_ctrl.sv
// Controller state machine for the multiset subset enumerator.
// Depends on msse_pkg; drives msse_dp through dp_cmd_t and reads dp_sts_t.
`timescale 1ns / 1ps

module msse_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic [msse_pkg::CMD_W-1:0]      req_cmd_i,
  input  msse_pkg::dp_sts_t               sts_i,
  output msse_pkg::dp_cmd_t               cmd_o
);

  msse_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msse_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          unique case (msse_pkg::cmd_e'(req_cmd_i))
            msse_pkg::CMD_LOAD: begin
              if (!sts_i.full) state_d = msse_pkg::ST_INS_TEST;
            end
            msse_pkg::CMD_NEXT: begin
              priority if (sts_i.finished) begin
                state_d = msse_pkg::ST_ONE_DONE;
              end else if (!sts_i.started) begin
                state_d = msse_pkg::ST_ONE_EMPTY;
              end else if (sts_i.can_push) begin
                state_d = msse_pkg::ST_EM_RD;
              end else if (sts_i.depth_zero) begin
                state_d = msse_pkg::ST_ONE_DONE;
              end else begin
                state_d = msse_pkg::ST_BT_RDV;
              end
            end
            default: state_d = msse_pkg::ST_IDLE;
          endcase
        end
      end
      msse_pkg::ST_INS_TEST: begin
        state_d = sts_i.p_zero ? msse_pkg::ST_IDLE : msse_pkg::ST_INS_CMP;
      end
      msse_pkg::ST_INS_CMP: begin
        state_d = sts_i.ins_gt ? msse_pkg::ST_INS_TEST : msse_pkg::ST_IDLE;
      end
      msse_pkg::ST_BT_RDV: state_d = msse_pkg::ST_BT_LDV;
      msse_pkg::ST_BT_LDV: begin
        priority if (!sts_i.top_end) begin
          state_d = msse_pkg::ST_BT_CMP;
        end else if (sts_i.depth_one) begin
          state_d = msse_pkg::ST_ONE_DONE;
        end else begin
          state_d = msse_pkg::ST_BT_RDV;
        end
      end
      msse_pkg::ST_BT_CMP: begin
        priority if (!sts_i.scan_eq) begin
          state_d = msse_pkg::ST_EM_RD;
        end else if (!sts_i.j_end) begin
          state_d = msse_pkg::ST_BT_CMP;
        end else if (sts_i.depth_one) begin
          state_d = msse_pkg::ST_ONE_DONE;
        end else begin
          state_d = msse_pkg::ST_BT_RDV;
        end
      end
      msse_pkg::ST_EM_RD: state_d = msse_pkg::ST_EM_WR;
      msse_pkg::ST_EM_WR: begin
        if (sts_i.out_free) begin
          state_d = sts_i.k_last ? msse_pkg::ST_IDLE : msse_pkg::ST_EM_RD;
        end
      end
      msse_pkg::ST_ONE_EMPTY, msse_pkg::ST_ONE_DONE: begin
        if (sts_i.out_free) state_d = msse_pkg::ST_IDLE;
      end
      default: state_d = msse_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = msse_pkg::RD_TOP;
    req_ready_o  = 1'b0;
    unique case (state_q)
      msse_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (msse_pkg::cmd_e'(req_cmd_i))
            msse_pkg::CMD_CLEAR: cmd_o.clear = 1'b1;
            msse_pkg::CMD_LOAD: begin
              cmd_o.restart = 1'b1;
              cmd_o.ld_val  = !sts_i.full;
            end
            msse_pkg::CMD_NEXT: begin
              priority if (sts_i.finished) begin
                cmd_o.out_kind = msse_pkg::OUT_DONE;
              end else if (!sts_i.started) begin
                cmd_o.start_empty = 1'b1;
              end else if (sts_i.can_push) begin
                cmd_o.push = 1'b1;
              end else if (sts_i.depth_zero) begin
                cmd_o.set_finished = 1'b1;
              end else begin
                cmd_o.rd_sel = msse_pkg::RD_TOP;
              end
            end
            default: cmd_o.rd_sel = msse_pkg::RD_TOP;
          endcase
        end
      end
      msse_pkg::ST_INS_TEST: begin
        cmd_o.rd_sel  = msse_pkg::RD_INS;
        cmd_o.ins_put = sts_i.p_zero;
      end
      msse_pkg::ST_INS_CMP: begin
        cmd_o.ins_step = sts_i.ins_gt;
        cmd_o.ins_put  = !sts_i.ins_gt;
      end
      msse_pkg::ST_BT_RDV: cmd_o.rd_sel = msse_pkg::RD_TOP;
      msse_pkg::ST_BT_LDV: begin
        cmd_o.rd_sel = msse_pkg::RD_TOP_P1;
        cmd_o.bt_ldv = 1'b1;
        if (sts_i.top_end) begin
          cmd_o.set_finished = sts_i.depth_one;
          cmd_o.pop          = !sts_i.depth_one;
        end
      end
      msse_pkg::ST_BT_CMP: begin
        cmd_o.rd_sel = msse_pkg::RD_J_P1;
        priority if (!sts_i.scan_eq) begin
          cmd_o.bt_set = 1'b1;
        end else if (!sts_i.j_end) begin
          cmd_o.bt_next = 1'b1;
        end else begin
          cmd_o.set_finished = sts_i.depth_one;
          cmd_o.pop          = !sts_i.depth_one;
        end
      end
      msse_pkg::ST_EM_RD: cmd_o.rd_sel = msse_pkg::RD_EMIT;
      msse_pkg::ST_EM_WR: begin
        cmd_o.rd_sel   = msse_pkg::RD_EMIT;
        cmd_o.out_kind = msse_pkg::OUT_ELEM;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.cnt_inc  = sts_i.k_last;
          cmd_o.k_inc    = !sts_i.k_last;
        end
      end
      msse_pkg::ST_ONE_EMPTY: begin
        cmd_o.out_kind = msse_pkg::OUT_EMPTY;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
        end
      end
      msse_pkg::ST_ONE_DONE: begin
        cmd_o.out_kind = msse_pkg::OUT_DONE;
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o.rd_sel = msse_pkg::RD_TOP;
    endcase
  end

endmodule

### rtl/msse_dp.sv
// Datapath of the multiset subset enumerator: sorted store memory, chosen
// positions, counters and the output register. Depends on msse_pkg.
`timescale 1ns / 1ps

module msse_dp #(
  parameter int unsigned MAX_ITEMS = msse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [msse_pkg::DATA_W-1:0] value_i,
  input  msse_pkg::dp_cmd_t                 cmd_i,
  output msse_pkg::dp_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [msse_pkg::DATA_W-1:0] element_value_o,
  output logic [msse_pkg::IDX_W-1:0]        position_o,
  output logic                              subset_empty_o,
  output logic                              last_element_o,
  output logic [msse_pkg::NUM_W-1:0]        subset_number_o,
  output logic                              done_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [msse_pkg::CNT_W-1:0] CAP = msse_pkg::CNT_W'(MAX_ITEMS);

  // Store and chosen-position arrays
  logic signed [msse_pkg::DATA_W-1:0] store_mem [MAX_ITEMS];
  logic [msse_pkg::IDX_W-1:0]         chosen_mem [MAX_ITEMS];

  logic signed [msse_pkg::DATA_W-1:0] rdata_q;
  logic signed [msse_pkg::DATA_W-1:0] val_q;
  logic signed [msse_pkg::DATA_W-1:0] cmp_q;
  logic [msse_pkg::CNT_W-1:0]         count_q;
  logic [msse_pkg::CNT_W-1:0]         depth_q;
  logic [msse_pkg::CNT_W-1:0]         j_q;
  logic [msse_pkg::IDX_W-1:0]         top_q;
  logic [msse_pkg::IDX_W-1:0]         k_q;
  logic                               started_q;
  logic                               finished_q;
  logic [msse_pkg::NUM_W-1:0]         counter_q;
  logic                               out_valid_q;

  logic [msse_pkg::CNT_W-1:0] top_p1;
  logic [msse_pkg::CNT_W-1:0] j_p1;
  logic [msse_pkg::CNT_W-1:0] k_p1;
  logic [msse_pkg::CNT_W-1:0] first;
  logic [msse_pkg::CNT_W-1:0] ch_addr;
  logic [msse_pkg::IDX_W-1:0] ch_rdata;
  logic [msse_pkg::CNT_W-1:0] rd_addr;
  logic [msse_pkg::CNT_W-1:0] ch_waddr;
  logic [msse_pkg::IDX_W-1:0] ch_wdata;
  logic                       st_we;
  logic signed [msse_pkg::DATA_W-1:0] st_wdata;

  assign top_p1 = {1'b0, top_q} + 1'b1;
  assign j_p1   = j_q + 1'b1;
  assign k_p1   = {1'b0, k_q} + 1'b1;
  assign first  = (depth_q == '0) ? '0 : top_p1;

  // Chosen-position read: level below the top on a pop, else the emit index
  assign ch_addr  = cmd_i.pop ? (depth_q - 5'd2) : {1'b0, k_q};
  assign ch_rdata = chosen_mem[ch_addr[AW-1:0]];

  // Store read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      msse_pkg::RD_INS:    rd_addr = j_q - 1'b1;
      msse_pkg::RD_TOP:    rd_addr = {1'b0, top_q};
      msse_pkg::RD_TOP_P1: rd_addr = top_p1;
      msse_pkg::RD_J_P1:   rd_addr = j_p1;
      msse_pkg::RD_EMIT:   rd_addr = {1'b0, ch_rdata};
      default:             rd_addr = {1'b0, top_q};
    endcase
  end

  // Store write: shift an entry up, or drop the new value in
  assign st_we    = cmd_i.ins_step | cmd_i.ins_put;
  assign st_wdata = cmd_i.ins_step ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[j_q[AW-1:0]] <= st_wdata;
    rdata_q <= store_mem[rd_addr[AW-1:0]];
  end

  // Chosen-position write: new level on a push, replace the top on a set
  assign ch_waddr = cmd_i.push ? depth_q : (depth_q - 1'b1);
  assign ch_wdata = cmd_i.push ? first[msse_pkg::IDX_W-1:0] : j_q[msse_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.bt_set) chosen_mem[ch_waddr[AW-1:0]] <= ch_wdata;
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_val) begin
      val_q <= value_i;
      j_q   <= count_q;
    end else if (cmd_i.ins_step) begin
      j_q <= j_q - 1'b1;
    end else if (cmd_i.bt_ldv) begin
      j_q <= top_p1;
    end else if (cmd_i.bt_next) begin
      j_q <= j_p1;
    end
    if (cmd_i.push) begin
      top_q <= first[msse_pkg::IDX_W-1:0];
    end else if (cmd_i.bt_set) begin
      top_q <= j_q[msse_pkg::IDX_W-1:0];
    end else if (cmd_i.pop) begin
      top_q <= ch_rdata;
    end
    if (cmd_i.push || cmd_i.bt_set) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_p1[msse_pkg::IDX_W-1:0];
    end
  end

  // Hold the value being skipped while backtracking
  always_ff @(posedge clk_i) begin
    if (cmd_i.bt_ldv) cmp_q <= rdata_q;
  end

  // Control state: fill count, depth, flags and subset counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      depth_q    <= '0;
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      counter_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.ins_put) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.clear || cmd_i.restart) begin
        depth_q    <= '0;
        started_q  <= 1'b0;
        finished_q <= 1'b0;
        counter_q  <= '0;
      end else begin
        if (cmd_i.start_empty) begin
          started_q <= 1'b1;
          depth_q   <= '0;
        end else if (cmd_i.push) begin
          depth_q <= depth_q + 1'b1;
        end else if (cmd_i.pop) begin
          depth_q <= depth_q - 1'b1;
        end
        if (cmd_i.set_finished) finished_q <= 1'b1;
        if (cmd_i.cnt_inc) counter_q <= counter_q + 1'b1;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      subset_number_o <= counter_q;
      unique case (cmd_i.out_kind)
        msse_pkg::OUT_ELEM: begin
          element_value_o <= rdata_q;
          position_o      <= k_q;
          subset_empty_o  <= 1'b0;
          last_element_o  <= sts_o.k_last;
          done_o          <= 1'b0;
        end
        msse_pkg::OUT_EMPTY: begin
          element_value_o <= '0;
          position_o      <= '0;
          subset_empty_o  <= 1'b1;
          last_element_o  <= 1'b1;
          done_o          <= 1'b0;
        end
        default: begin
          element_value_o <= '0;
          position_o      <= '0;
          subset_empty_o  <= 1'b0;
          last_element_o  <= 1'b1;
          done_o          <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign sts_o.full       = (count_q >= CAP);
  assign sts_o.started    = started_q;
  assign sts_o.finished   = finished_q;
  assign sts_o.can_push   = (first < count_q);
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.depth_one  = (depth_q == 5'd1);
  assign sts_o.p_zero     = (j_q == '0);
  assign sts_o.ins_gt     = (rdata_q > val_q);
  assign sts_o.top_end    = (top_p1 >= count_q);
  assign sts_o.j_end      = (j_p1 >= count_q);
  assign sts_o.scan_eq    = (rdata_q == cmp_q);
  assign sts_o.k_last     = (k_p1 == depth_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### tb/msse_subset_tracker.sv
// Request and result tracker for the multiset subset enumerator testbench.
// Predicts every result from the accepted requests and compares the stream.
// Depends on msse_pkg for the request codes and the default store depth.
`timescale 1ns / 1ps

module msse_subset_tracker #(
  parameter int unsigned STORE_DEPTH = msse_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // [31:0] element_value, [35:32] position_in_subset,
                                      // [51:36] subset_number, [55:52] zero
  input  logic [1:0]  m_axis_tuser,   // [0] subset_empty, [1] done_res
  input  logic        m_axis_tlast,   // last_element
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [31:0] elem;
    logic [3:0]  pos;
    logic        empty;
    logic        last;
    logic [15:0] num;
    logic        done;
  } subset_beat_t;

  // Own copy of the enumerator state
  logic [31:0]  held_values [STORE_DEPTH];
  int           held_count;
  logic [3:0]   pick_idx [16];
  int           pick_depth;
  bit           empty_given;
  bit           walk_over;
  logic [15:0]  sets_given;

  subset_beat_t subset_beats_due [$];
  int unsigned  fail_total;

  // Restart the walk: the next request gives the empty set again
  function automatic void restart_walk();
    pick_depth  = 0;
    empty_given = 1'b0;
    walk_over   = 1'b0;
    sets_given  = '0;
  endfunction

  function automatic void queue_beat(logic [31:0] elem, logic [3:0] pos, logic empty,
                                     logic last, logic done);
    subset_beat_t b;
    b.elem  = elem;
    b.pos   = pos;
    b.empty = empty;
    b.last  = last;
    b.num   = sets_given;
    b.done  = done;
    subset_beats_due.push_back(b);
  endfunction

  // Depth-first step: extend by the next entry, else backtrack past equal values
  function automatic bit step_to_next_subset();
    int          first;
    int          lvl;
    int          j;
    logic [31:0] v;
    first = (pick_depth == 0) ? 0 : int'(pick_idx[pick_depth-1]) + 1;
    if (pick_depth < 16 && first < held_count) begin
      pick_idx[pick_depth] = first[3:0];
      pick_depth++;
      return 1'b1;
    end
    while (pick_depth > 0) begin
      lvl = pick_depth - 1;
      v   = held_values[pick_idx[lvl]];
      j   = int'(pick_idx[lvl]);
      while (j < held_count && held_values[j] == v) j++;
      if (j < held_count) begin
        pick_idx[lvl] = j[3:0];
        return 1'b1;
      end
      pick_depth--;
    end
    return 1'b0;
  endfunction

  function automatic void predict_request(logic [1:0] cmd, logic [31:0] value);
    int p;
    case (cmd)
      msse_pkg::CMD_CLEAR: begin
        held_count = 0;
        restart_walk();
      end
      msse_pkg::CMD_LOAD: begin
        // Insert in signed order; drop the value when the store is full
        if (held_count < int'(STORE_DEPTH)) begin
          p = held_count;
          while (p > 0 && $signed(held_values[p-1]) > $signed(value)) begin
            held_values[p] = held_values[p-1];
            p--;
          end
          held_values[p] = value;
          held_count++;
        end
        restart_walk();
      end
      msse_pkg::CMD_NEXT: begin
        if (walk_over) begin
          queue_beat('0, '0, 1'b0, 1'b1, 1'b1);
        end else if (!empty_given) begin
          empty_given = 1'b1;
          pick_depth  = 0;
          queue_beat('0, '0, 1'b1, 1'b1, 1'b0);
          sets_given++;
        end else if (!step_to_next_subset()) begin
          walk_over = 1'b1;
          queue_beat('0, '0, 1'b0, 1'b1, 1'b1);
        end else begin
          for (int k = 0; k < pick_depth; k++) begin
            queue_beat(held_values[pick_idx[k]], k[3:0], 1'b0, (k + 1 == pick_depth), 1'b0);
          end
          sets_given++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_beat();
    subset_beat_t got;
    subset_beat_t want;
    got.elem  = m_axis_tdata[31:0];
    got.pos   = m_axis_tdata[35:32];
    got.num   = m_axis_tdata[51:36];
    got.empty = m_axis_tuser[0];
    got.done  = m_axis_tuser[1];
    got.last  = m_axis_tlast;
    if (subset_beats_due.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("unexpected result: elem %h pos %0d empty %b last %b num %0d done %b",
                 got.elem, got.pos, got.empty, got.last, got.num, got.done);
    end else begin
      want = subset_beats_due.pop_front();
      if (got != want) begin
        fail_total++;
        if (fail_total <= 10) begin
          $display("result mismatch, expected: elem %h pos %0d empty %b last %b num %0d done %b",
                   want.elem, want.pos, want.empty, want.last, want.num, want.done);
          $display("                      got: elem %h pos %0d empty %b last %b num %0d done %b",
                   got.elem, got.pos, got.empty, got.last, got.num, got.done);
        end
      end
    end
  endfunction

  // Check results before adding the predictions of a request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      restart_walk();
      subset_beats_due.delete();
      fail_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
      fail_count_o <= fail_total;
      pending_o    <= subset_beats_due.size();
    end
  end

endmodule

### tb/multiset_subset_enumerator_top_tb.sv
// Testbench top for the multiset subset enumerator: clock, reset, request
// stimulus and receiver back-pressure, with the verdict at the end.
// Depends on msse_pkg, msse_subset_tracker and multiset_subset_enumerator_top.
`timescale 1ns / 1ps

module multiset_subset_enumerator_top_tb;

  localparam int unsigned STORE_DEPTH     = msse_pkg::MAX_ITEMS_DEF;
  localparam int unsigned RANDOM_REQUESTS = 480;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned NEXT_CAP        = 80;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic [1:0]  s_axis_tuser;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;   // [31:0] element_value, [35:32] position_in_subset,
                               // [51:36] subset_number, [55:52] zero
  logic [1:0]  m_axis_tuser;   // [0] subset_empty, [1] done_res
  logic        m_axis_tlast;   // last_element

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 80;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  int unsigned fail_count;
  int unsigned pending;
  logic [31:0] loaded_values [$];

  bit          hold_off_go   = 1'b0;
  bit          hold_off_used = 1'b0;
  int unsigned hold_off_left = 0;

  multiset_subset_enumerator_top #(
    .MAX_ITEMS(STORE_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  msse_subset_tracker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_go && !hold_off_used) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_used <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (cmd == msse_pkg::CMD_CLEAR) loaded_values.delete();
    else if (cmd == msse_pkg::CMD_LOAD && loaded_values.size() < STORE_DEPTH)
      loaded_values.push_back(value);
  endtask

  // Distinct sub-multisets of the held values: product of (multiplicity + 1)
  function automatic longint unsigned count_subsets();
    logic [31:0]     vals [$];
    longint unsigned total;
    int              run;
    vals  = loaded_values;
    vals.sort();
    total = 1;
    run   = 0;
    foreach (vals[i]) begin
      run++;
      if (i == vals.size() - 1 || vals[i+1] != vals[i]) begin
        total = total * (run + 1);
        run   = 0;
      end
    end
    return total;
  endfunction

  // One load-then-walk run with random content, or a burst of noise
  task automatic run_sequence();
    logic [31:0]     pool [4];
    int unsigned     shape;
    int unsigned     n_loads;
    int unsigned     pool_size;
    longint unsigned total;
    longint unsigned n_next;
    shape = $urandom_range(0, 99);
    foreach (pool[k])
      pool[k] = ($urandom_range(0, 3) != 0) ? 32'($urandom)
              : ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    if (shape >= 95) begin
      repeat ($urandom_range(4, 8)) send_request(2'($urandom_range(0, 3)), $urandom);
    end else begin
      if ($urandom_range(0, 99) < 85) send_request(msse_pkg::CMD_CLEAR, $urandom);
      if (shape < 55) begin
        n_loads   = $urandom_range(0, 5);
        pool_size = 4;
      end else if (shape < 85) begin
        n_loads   = $urandom_range(6, 9);
        pool_size = 3;
      end else begin
        // fill the store and overflow it
        n_loads   = STORE_DEPTH + $urandom_range(1, 2);
        pool_size = $urandom_range(1, 3);
      end
      repeat (n_loads)
        send_request(msse_pkg::CMD_LOAD,
                     (shape < 55 && $urandom_range(0, 1) == 0) ? 32'($urandom)
                     : pool[$urandom_range(0, pool_size - 1)]);
      total = count_subsets();
      if ($urandom_range(0, 99) < 25)
        n_next = $urandom_range(1, (total > NEXT_CAP) ? NEXT_CAP : int'(total));
      else
        n_next = total + 1 + $urandom_range(0, 2);
      if (n_next > NEXT_CAP) n_next = NEXT_CAP;
      repeat (n_next) send_request(msse_pkg::CMD_NEXT, $urandom);
    end
  endtask

  initial begin
    int unsigned base;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= msse_pkg::CMD_CLEAR;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes with a duplicate, walked to the end and past it
    send_request(msse_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    send_request(msse_pkg::CMD_LOAD, 32'h7FFF_FFFF);
    send_request(msse_pkg::CMD_LOAD, 32'h8000_0000);
    send_request(msse_pkg::CMD_LOAD, 32'h7FFF_FFFF);
    send_request(msse_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    repeat (14) send_request(msse_pkg::CMD_NEXT, 32'h0000_0000);
    // Unused code, then the walk of an empty store
    send_request(CMD_UNUSED, 32'h5A5A_A5A5);
    send_request(msse_pkg::CMD_CLEAR, 32'h0000_0000);
    send_request(msse_pkg::CMD_NEXT, 32'hFFFF_FFFF);
    send_request(msse_pkg::CMD_NEXT, 32'h0000_0000);

    base = requests_sent;
    while (requests_sent < base + RANDOM_REQUESTS / 3) run_sequence();
    send_idle_pct = 80;
    recv_idle_pct = 16;
    while (requests_sent < base + 2 * RANDOM_REQUESTS / 3) run_sequence();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Full store of one value, then keep requesting while the receiver holds off
    send_request(msse_pkg::CMD_CLEAR, $urandom);
    repeat (STORE_DEPTH) send_request(msse_pkg::CMD_LOAD, 32'h8000_0000);
    hold_off_go <= 1'b1;
    repeat (STORE_DEPTH + 3) send_request(msse_pkg::CMD_NEXT, $urandom);
    while (requests_sent < base + RANDOM_REQUESTS) run_sequence();
    s_axis_tvalid <= 1'b0;

    // Drain the results still due
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
